>>> design/bba_pkg.sv
// Package: widths, codes, item types and the free-map indexing helper.
package bba_pkg;

  localparam int MAX_POOL_ORDER = 16;
  localparam int MIN_ORDER      = 4;
  localparam int HEADER_BYTES   = 8;
  localparam int ORD_W          = 5;
  localparam int OFF_W          = MAX_POOL_ORDER;
  localparam int REQ_W          = MAX_POOL_ORDER + 1;
  localparam int SLOT_W         = MAX_POOL_ORDER - MIN_ORDER;
  localparam int NODE_W         = SLOT_W + 1;
  localparam int SLOTS          = 1 << SLOT_W;
  localparam int NODES          = 1 << NODE_W;

  localparam logic [ORD_W-1:0] POOL_ORDER_RESET = ORD_W'(MAX_POOL_ORDER);

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BADFREE = 2'd2
  } status_t;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [REQ_W-1:0] request_size;
    logic [OFF_W-1:0] block_offset;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [OFF_W-1:0] granted_offset;
    logic [ORD_W-1:0] granted_order;
  } rsp_t;

  // Free-map node of the block of order o at byte offset off.
  function automatic logic [NODE_W-1:0] node_of(input logic [ORD_W-1:0] o,
                                                input logic [OFF_W-1:0] off);
    logic [NODE_W:0]  base;
    logic [OFF_W-1:0] idx;
    base = ((NODE_W+1)'(1) << (ORD_W'(MAX_POOL_ORDER) - o)) - (NODE_W+1)'(1);
    idx  = off >> o;
    return NODE_W'(base + (NODE_W+1)'(idx));
  endfunction

endpackage

>>> design/buddy_block_allocator_top.sv
// Top level: buddy allocator with free map, order table and step sequencer.
//
// Buddy allocator over a pool of 2^pool_order bytes, minimum block 16 bytes.
// Pulse start while busy is low to hand over one item (allocate or free).
// The single result appears on rsp for exactly one cycle with done high and
// cannot be held off. After reset, or after any write of pool_order, the
// block clears its free map and order table and stays busy meanwhile. An
// allocate first sizes the request, then probes free-map nodes (nodes of
// order need and upward, lowest address first, up to 8191 in the worst case),
// then claims the block found and splits it down to order need. A free reads
// the order table and then merges with free buddies level by level; an offset
// outside the pool or not aligned is rejected straight from idle. The free
// map has a single read port and is probed one node at a time.
module buddy_block_allocator_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  bba_pkg::req_t       req,
  output logic                busy,
  output logic                done,
  output bba_pkg::rsp_t       rsp,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import bba_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_NEED, S_SCAN_RD, S_SCAN_CHK, S_CLAIM, S_SPLIT,
    S_FREE_RD, S_FREE_CHK, S_COAL_RD, S_COAL_CHK
  } state_t;

  state_t             state;
  logic [ORD_W-1:0]   pool_order;
  logic [NODE_W-1:0]  cnt;
  logic [ORD_W-1:0]   need;
  logic [ORD_W-1:0]   ord;
  logic [SLOT_W-1:0]  idx;
  logic [OFF_W-1:0]   off;
  logic [REQ_W:0]     need_bytes;

  // Free map and order table.
  logic               tree [NODES];
  logic [ORD_W-1:0]   otab [SLOTS];
  logic               tree_we, tree_wd, tree_rd;
  logic [NODE_W-1:0]  tree_wa, tree_ra;
  logic               otab_we;
  logic [SLOT_W-1:0]  otab_wa, otab_ra;
  logic [ORD_W-1:0]   otab_wd, otab_rd;

  logic               cfg_wr;
  logic [ORD_W-1:0]   cfg_clamped;
  logic [OFF_W-1:0]   scan_off, buddy_off;
  logic [SLOT_W-1:0]  scan_last;
  logic [NODE_W-1:0]  root_node;

  assign pready = 1'b1;
  assign prdata = {{(32-ORD_W){1'b0}}, pool_order};
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign busy   = (state != S_IDLE);

  always_comb begin
    if (pwdata[ORD_W-1:0] < ORD_W'(MIN_ORDER)) begin
      cfg_clamped = ORD_W'(MIN_ORDER);
    end else if (pwdata[ORD_W-1:0] > ORD_W'(MAX_POOL_ORDER)) begin
      cfg_clamped = ORD_W'(MAX_POOL_ORDER);
    end else begin
      cfg_clamped = pwdata[ORD_W-1:0];
    end
  end

  // Offset under probe, the buddy of the block being merged, last probe index.
  assign scan_off  = OFF_W'(idx) << ord;
  assign buddy_off = off ^ (OFF_W'(1) << ord);
  assign scan_last = SLOT_W'(((SLOT_W+1)'(1) << (pool_order - ord)) - (SLOT_W+1)'(1));
  assign root_node = node_of(pool_order, '0);

  // Memory port control from the sequencer step.
  always_comb begin
    tree_we = 1'b0;
    tree_wa = node_of(ord, off);
    tree_wd = 1'b0;
    tree_ra = node_of(ord, scan_off);
    otab_we = 1'b0;
    otab_wa = off[OFF_W-1:MIN_ORDER];
    otab_wd = '0;
    otab_ra = off[OFF_W-1:MIN_ORDER];
    unique case (state)
      S_CLEAR: begin
        tree_we = 1'b1;
        tree_wa = cnt;
        tree_wd = (cnt == root_node);
        otab_we = !cnt[NODE_W-1];
        otab_wa = cnt[SLOT_W-1:0];
      end
      S_CLAIM: tree_we = 1'b1;
      S_SPLIT: begin
        if (ord > need) begin
          // free the upper half left over by this split
          tree_we = 1'b1;
          tree_wa = node_of(ord - ORD_W'(1), off | (OFF_W'(1) << (ord - ORD_W'(1))));
          tree_wd = 1'b1;
        end else begin
          otab_we = 1'b1;
          otab_wd = need;
        end
      end
      S_FREE_CHK: otab_we = !(otab_rd < ORD_W'(MIN_ORDER) || otab_rd > pool_order);
      S_COAL_RD:  tree_ra = node_of(ord, buddy_off);
      S_COAL_CHK: begin
        tree_we = 1'b1;
        if (ord < pool_order && tree_rd) begin
          tree_wa = node_of(ord, buddy_off);
        end else begin
          tree_wd = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (tree_we) begin
      tree[tree_wa] <= tree_wd;
    end
    tree_rd <= tree[tree_ra];
    if (otab_we) begin
      otab[otab_wa] <= otab_wd;
    end
    otab_rd <= otab[otab_ra];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      pool_order <= POOL_ORDER_RESET;
      cnt        <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_wr) begin
        // new pool size: empty the pool again
        pool_order <= cfg_clamped;
        cnt        <= '0;
        state      <= S_CLEAR;
      end else begin
        unique case (state)
          S_CLEAR: begin
            cnt <= cnt + NODE_W'(1);
            if (cnt == NODE_W'(NODES - 1)) begin
              state <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (start) begin
              rsp.granted_offset <= '0;
              rsp.granted_order  <= '0;
              off        <= req.block_offset;
              need       <= ORD_W'(MIN_ORDER);
              need_bytes <= (REQ_W+1)'(req.request_size) + (REQ_W+1)'(HEADER_BYTES);
              if (req.mode == MODE_ALLOC) begin
                state <= S_NEED;
              end else if (((OFF_W+1)'(req.block_offset) >> pool_order) != '0 ||
                           req.block_offset[MIN_ORDER-1:0] != '0) begin
                rsp.status <= ST_BADFREE;
                done       <= 1'b1;
              end else begin
                state <= S_FREE_RD;
              end
            end
          end
          S_NEED: begin
            if (((REQ_W+1)'(1) << need) >= need_bytes) begin
              if (need > pool_order) begin
                rsp.status <= ST_NOSPACE;
                done       <= 1'b1;
                state      <= S_IDLE;
              end else begin
                ord   <= need;
                idx   <= '0;
                state <= S_SCAN_RD;
              end
            end else if (need >= pool_order) begin
              rsp.status <= ST_NOSPACE;
              done       <= 1'b1;
              state      <= S_IDLE;
            end else begin
              need <= need + ORD_W'(1);
            end
          end
          S_SCAN_RD: state <= S_SCAN_CHK;
          S_SCAN_CHK: begin
            if (tree_rd) begin
              off   <= scan_off;
              state <= S_CLAIM;
            end else if (idx == scan_last) begin
              idx <= '0;
              if (ord >= pool_order) begin
                rsp.status <= ST_NOSPACE;
                done       <= 1'b1;
                state      <= S_IDLE;
              end else begin
                ord   <= ord + ORD_W'(1);
                state <= S_SCAN_RD;
              end
            end else begin
              idx   <= idx + SLOT_W'(1);
              state <= S_SCAN_RD;
            end
          end
          S_CLAIM: state <= S_SPLIT;
          S_SPLIT: begin
            if (ord > need) begin
              ord <= ord - ORD_W'(1);
            end else begin
              rsp.status         <= ST_OK;
              rsp.granted_offset <= off;
              rsp.granted_order  <= need;
              done               <= 1'b1;
              state              <= S_IDLE;
            end
          end
          S_FREE_RD: state <= S_FREE_CHK;
          S_FREE_CHK: begin
            if (otab_rd < ORD_W'(MIN_ORDER) || otab_rd > pool_order) begin
              rsp.status <= ST_BADFREE;
              done       <= 1'b1;
              state      <= S_IDLE;
            end else begin
              ord   <= otab_rd;
              state <= S_COAL_RD;
            end
          end
          S_COAL_RD: state <= S_COAL_CHK;
          S_COAL_CHK: begin
            if (ord < pool_order && tree_rd) begin
              // merge with the free buddy and climb a level
              off   <= off & ~(OFF_W'(1) << ord);
              ord   <= ord + ORD_W'(1);
              state <= S_COAL_RD;
            end else begin
              rsp.status <= ST_OK;
              done       <= 1'b1;
              state      <= S_IDLE;
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

endmodule

>>> design/bba_checker.sv
// Checker: port-level properties of the allocator, bound to the top level.
module bba_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input bba_pkg::rsp_t rsp
);
  import bba_pkg::*;

  // A rejected offset answers at once; anything else goes busy.
  a_take: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done) else $error("item taken without going busy");

  a_pulse: assert property (@(posedge clk) disable iff (rst)
    done && !(start && !busy) |=> !done) else $error("result strobe longer than one cycle");

  a_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result shown while busy");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status != ST_OK |-> rsp.granted_offset == '0 && rsp.granted_order == '0)
    else $error("failed item carries a grant");

  a_code: assert property (@(posedge clk) disable iff (rst)
    done |-> rsp.status == ST_OK || rsp.status == ST_NOSPACE || rsp.status == ST_BADFREE)
    else $error("unknown status code");

endmodule

bind buddy_block_allocator_top bba_checker u_bba_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .rsp(rsp)
);
